@@ hdl/bse_pkg.sv @@
package bse_pkg;

  localparam int unsigned DataW      = 32;
  localparam int unsigned SetSizeDef = 16;

  // One slot of the sorter chain: a value and whether it is present
  typedef struct packed {
    logic                    valid;
    logic signed [DataW-1:0] data;
  } cell_link_t;

  typedef enum logic [2:0] {
    StLoad  = 3'b001,
    StFlush = 3'b010,
    StDrain = 3'b100
  } state_e;

endpackage

@@ hdl/bse_cell.sv @@
module bse_cell (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                shift_i,
  input  bse_pkg::cell_link_t left_i,
  input  bse_pkg::cell_link_t right_i,
  output bse_pkg::cell_link_t stored_o,
  output bse_pkg::cell_link_t pass_o
);
  import bse_pkg::*;

  cell_link_t stored_q, stored_d;
  cell_link_t pass_q, pass_d;

  always_comb begin
    stored_d       = stored_q;
    pass_d         = left_i;
    pass_d.valid   = 1'b0;
    if (shift_i) begin
      // drain: take the right neighbor's value
      stored_d = right_i;
    end else if (left_i.valid) begin
      if (!stored_q.valid) begin
        stored_d = left_i;
      end else if (left_i.data < stored_q.data) begin
        // keep the smaller, hand the larger onward
        stored_d = left_i;
        pass_d   = stored_q;
      end else begin
        // equal values pass, so earlier arrivals stay ahead
        pass_d = left_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stored_q <= '0;
      pass_q   <= '0;
    end else begin
      stored_q <= stored_d;
      pass_q   <= pass_d;
    end
  end

  assign stored_o = stored_q;
  assign pass_o   = pass_q;

endmodule

@@ hdl/bubble_sort_engine.sv @@
// Sorting engine for sets of SET_SIZE signed 32-bit values.
// Input channel: in_valid_i / in_ready_o carry one value_i per transaction.
// After SET_SIZE input transactions the set is complete. The output channel
// (out_valid_o / out_ready_i) then returns the set in ascending order, one
// sorted_value_o per transaction, with last_of_set_o high on the largest
// value. Equal values come out in their arrival order.
// Values enter a chain of SET_SIZE compare-and-keep cells; each cell keeps
// the smaller value and hands the larger one to its right neighbor.
// Each set passes through three phases: loading at one value per cycle, then
// settling while the last value passes through the chain, then draining as
// the chain shifts toward cell 0.
// in_ready_o is low while settling and draining. When the receiver stalls,
// the output register holds its value and the chain stops shifting.
// Reset empties the chain and starts a new set; no results are pending.
module bubble_sort_engine #(
  parameter int unsigned SET_SIZE = bse_pkg::SetSizeDef
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic signed [bse_pkg::DataW-1:0] value_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic signed [bse_pkg::DataW-1:0] sorted_value_o,
  output logic                             last_of_set_o
);
  import bse_pkg::*;

  localparam int unsigned CntW = $clog2(SET_SIZE);

  state_e              state_q, state_d;
  logic [CntW-1:0]     cnt_q, cnt_d;
  logic                out_valid_q, out_valid_d;
  logic signed [DataW-1:0] out_data_q, out_data_d;
  logic                out_last_q, out_last_d;
  logic                shift;
  logic                cnt_end;

  cell_link_t          left   [SET_SIZE];
  cell_link_t          right  [SET_SIZE];
  cell_link_t          stored [SET_SIZE];
  cell_link_t          pass   [SET_SIZE];

  assign in_ready_o = (state_q == StLoad);
  assign cnt_end    = (cnt_q == CntW'(SET_SIZE - 1));
  assign shift      = (state_q == StDrain) && (!out_valid_q || out_ready_i);

  for (genvar i = 0; i < SET_SIZE; i++) begin : g_cell
    if (i == 0) begin : g_first
      assign left[i] = {in_valid_i && in_ready_o, value_i};
    end else begin : g_next
      assign left[i] = pass[i-1];
    end
    if (i == SET_SIZE - 1) begin : g_last
      assign right[i] = '0;
    end else begin : g_inner
      assign right[i] = stored[i+1];
    end

    bse_cell u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .shift_i  (shift),
      .left_i   (left[i]),
      .right_i  (right[i]),
      .stored_o (stored[i]),
      .pass_o   (pass[i])
    );
  end

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;
    out_last_d  = out_last_q;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      StLoad: begin
        if (in_valid_i) begin
          if (cnt_end) begin
            cnt_d   = '0;
            state_d = StFlush;
          end else begin
            cnt_d = cnt_q + 1'b1;
          end
        end
      end
      StFlush: begin
        // let the last value settle through the chain
        if (cnt_end) begin
          cnt_d   = '0;
          state_d = StDrain;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      StDrain: begin
        if (shift) begin
          out_valid_d = 1'b1;
          out_data_d  = stored[0].data;
          out_last_d  = cnt_end;
          if (cnt_end) begin
            cnt_d   = '0;
            state_d = StLoad;
          end else begin
            cnt_d = cnt_q + 1'b1;
          end
        end
      end
      default: begin
        state_d = StLoad;
        cnt_d   = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StLoad;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q <= out_data_d;
    out_last_q <= out_last_d;
  end

  assign out_valid_o    = out_valid_q;
  assign sorted_value_o = out_data_q;
  assign last_of_set_o  = out_last_q;

endmodule

@@ sim/testbench.sv @@
`timescale 1ns / 1ps

module testbench;
  import bse_pkg::DataW;

  localparam int unsigned SetSize    = bse_pkg::SetSizeDef;
  localparam int unsigned DirRows    = 24;
  localparam int unsigned RandItems  = 264;
  localparam int unsigned CycleLimit = 200000;

  typedef logic signed [DataW-1:0] word_t;

  typedef struct {
    word_t sorted_value;
    logic  last_of_set;
  } sorted_item_t;

  typedef struct {
    word_t value;
    bit    typed;
    word_t sorted_value;
  } dir_row_t;

  logic  clk_i       = 1'b0;
  logic  rst_ni      = 1'b0;
  logic  in_valid_q  = 1'b0;
  word_t in_value_q  = '0;
  logic  out_ready_q = 1'b0;
  logic  in_ready_o;
  logic  out_valid_o;
  word_t sorted_value_o;
  logic  last_of_set_o;

  word_t        set_store [SetSize];
  int unsigned  set_fill;
  sorted_item_t sorted_q [$];
  int unsigned  mismatch_cnt;
  int unsigned  cycle_cnt;
  bit           src_quiet;
  bit           snk_quiet;
  dir_row_t     dir_tab [DirRows];

  bubble_sort_engine #(
    .SET_SIZE(SetSize)
  ) i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_q),
    .in_ready_o    (in_ready_o),
    .value_i       (in_value_q),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_q),
    .sorted_value_o(sorted_value_o),
    .last_of_set_o (last_of_set_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CycleLimit) begin
      $display("status: fail");
      $finish;
    end
  end

  // Quiet stretches flip on and off now and then; inside one, no waits at all.
  function automatic int unsigned draw_wait(inout bit quiet);
    if ($urandom_range(0, 19) == 0) quiet = !quiet;
    return quiet ? 0 : $urandom_range(0, 9);
  endfunction

  // Store one accepted value; returns 1 when it completes the set.
  function automatic bit store_value(input word_t v);
    set_store[set_fill] = v;
    set_fill++;
    if (set_fill < SetSize) return 1'b0;
    set_fill = 0;
    return 1'b1;
  endfunction

  // Stable bubble sort of the full set, then queue it smallest first.
  function automatic void queue_sorted_set();
    word_t        vals [SetSize];
    word_t        tmp;
    bit           swapped;
    sorted_item_t item;
    vals = set_store;
    for (int p = 0; p < SetSize - 1; p++) begin
      swapped = 1'b0;
      for (int k = 0; k < SetSize - 1 - p; k++) begin
        if (vals[k] > vals[k+1]) begin
          tmp       = vals[k];
          vals[k]   = vals[k+1];
          vals[k+1] = tmp;
          swapped   = 1'b1;
        end
      end
      if (!swapped) break;
    end
    for (int k = 0; k < SetSize; k++) begin
      item.sorted_value = vals[k];
      item.last_of_set  = (k == SetSize - 1);
      sorted_q.push_back(item);
    end
  endfunction

  // Hold valid until the transaction is taken; valid is only lowered for a gap.
  task automatic send_value(input word_t v, input int unsigned gap);
    if (gap > 0) begin
      in_valid_q <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_q <= 1'b1;
    in_value_q <= v;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
  endtask

  // Result side: random stalls, then check each transaction in order.
  initial begin
    int unsigned  stall_left;
    sorted_item_t exp;
    stall_left = draw_wait(snk_quiet);
    forever begin
      out_ready_q <= (stall_left == 0);
      @(posedge clk_i);
      if (rst_ni && out_valid_o && out_ready_q) begin
        if (sorted_q.size() == 0) begin
          mismatch_cnt++;
          $display("%0t: unexpected result sorted_value=%0d last_of_set=%0b",
                   $time, sorted_value_o, last_of_set_o);
        end else begin
          exp = sorted_q.pop_front();
          if (sorted_value_o !== exp.sorted_value) begin
            mismatch_cnt++;
            $display("%0t: sorted_value expected %0d actual %0d",
                     $time, exp.sorted_value, sorted_value_o);
          end
          if (last_of_set_o !== exp.last_of_set) begin
            mismatch_cnt++;
            $display("%0t: last_of_set expected %0b actual %0b",
                     $time, exp.last_of_set, last_of_set_o);
          end
        end
        stall_left = draw_wait(snk_quiet);
      end else if (stall_left > 0) begin
        stall_left--;
      end
    end
  end

  initial begin
    int unsigned  shape;
    word_t        v;
    word_t        run;
    sorted_item_t item;
    // First set: extremes and duplicates, sorted order typed in per row.
    dir_tab = '{
      '{32'sh0000_0000, 1'b1, 32'sh8000_0000},
      '{32'shFFFF_FFFF, 1'b1, 32'sh8000_0001},
      '{32'sh0000_0001, 1'b1, 32'shC000_0000},
      '{32'sh7FFF_FFFF, 1'b1, -32'sd100},
      '{32'sh8000_0000, 1'b1, -32'sd5},
      '{32'sh7FFF_FFFE, 1'b1, -32'sd1},
      '{32'sh8000_0001, 1'b1, 32'sd0},
      '{32'sd5,         1'b1, 32'sd0},
      '{-32'sd5,        1'b1, 32'sd1},
      '{32'sd5,         1'b1, 32'sd2},
      '{32'sd0,         1'b1, 32'sd5},
      '{32'sd100,       1'b1, 32'sd5},
      '{-32'sd100,      1'b1, 32'sd100},
      '{32'sh4000_0000, 1'b1, 32'sh4000_0000},
      '{32'shC000_0000, 1'b1, 32'sh7FFF_FFFE},
      '{32'sd2,         1'b1, 32'sh7FFF_FFFF},
      // start of the next set: runs of equal and descending values
      '{-32'sd7,        1'b0, 32'sd0},
      '{-32'sd7,        1'b0, 32'sd0},
      '{-32'sd7,        1'b0, 32'sd0},
      '{32'sh7FFF_FFFF, 1'b0, 32'sd0},
      '{32'sd3,         1'b0, 32'sd0},
      '{32'sd2,         1'b0, 32'sd0},
      '{32'sd1,         1'b0, 32'sd0},
      '{32'sh8000_0000, 1'b0, 32'sd0}
    };
    set_fill     = 0;
    mismatch_cnt = 0;
    cycle_cnt    = 0;
    src_quiet    = 1'b0;
    snk_quiet    = 1'b0;
    shape        = 0;
    run          = '0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int r = 0; r < DirRows; r++) begin
      send_value(dir_tab[r].value, draw_wait(src_quiet));
      if (store_value(dir_tab[r].value)) begin
        if (dir_tab[r].typed) begin
          for (int k = 0; k < SetSize; k++) begin
            item.sorted_value = dir_tab[r-SetSize+1+k].sorted_value;
            item.last_of_set  = (k == SetSize - 1);
            sorted_q.push_back(item);
          end
        end else begin
          queue_sorted_set();
        end
      end
    end

    for (int n = 0; n < RandItems; n++) begin
      // Pick a shape for each new set: random, dense duplicates, presorted,
      // reversed, or near the extremes.
      if (set_fill == 0) begin
        shape = $urandom_range(0, 4);
        run   = $urandom;
      end
      case (shape)
        0: v = $urandom;
        1: v = $signed($urandom_range(0, 6)) - 3;
        2: begin
          run = run + $urandom_range(0, 5000);
          v   = run;
        end
        3: begin
          run = run - $urandom_range(0, 5000);
          v   = run;
        end
        default: begin
          v = $urandom_range(0, 1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
          v = v + $signed($urandom_range(0, 4)) - 2;
        end
      endcase
      send_value(v, draw_wait(src_quiet));
      if (store_value(v)) queue_sorted_set();
    end
    in_valid_q <= 1'b0;

    while (sorted_q.size() != 0) @(posedge clk_i);
    repeat (4 * SetSize) @(posedge clk_i);
    if (mismatch_cnt == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

@@ bubble_sort_engine.f @@
hdl/bse_pkg.sv
hdl/bse_cell.sv
hdl/bubble_sort_engine.sv
sim/testbench.sv
